### hdl/ssd_pwm_pkg.sv
// Shared constants, types and helper functions of the seven-segment PWM frame builder.
package ssd_pwm_pkg;

  // PWM run length and the widths that follow from it
  localparam int STEP_COUNT = 32;
  localparam int STEP_W     = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
  localparam int LVL_W      = $clog2(STEP_COUNT + 1);

  // Frame geometry
  localparam int DIGIT_COUNT = 14;
  localparam int FRAME_W     = 8 * DIGIT_COUNT;
  localparam int STEP_OUT_W  = 5;

  // Stream widths
  localparam int IN_W         = 52;
  localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W        = FRAME_W + STEP_OUT_W;
  localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRIGHTNESS = 2'd0,
    CFG_DIGIT_LOW  = 2'd1,
    CFG_DIGIT_HIGH = 2'd2
  } cfg_reg_t;

  // Segment a..g in bit 0..6, and the pin each segment drives
  localparam logic [6:0] SEGS [10] = '{
    7'h3F, 7'h05, 7'h6E, 7'h4F, 7'h55, 7'h5B, 7'h7B, 7'h07, 7'h7F, 7'h5F
  };
  localparam int unsigned PERM [8] = '{2, 0, 1, 3, 5, 4, 6, 7};
  localparam int unsigned DP_PIN = 7;

  // One decimal digit and what is left below it
  typedef struct packed {
    logic [3:0] digit;
    logic [9:0] rest;
  } split_t;

  // Map a decimal digit to its output pin pattern
  function automatic logic [7:0] seg_pins(input logic [3:0] d);
    logic [6:0] src;
    logic [7:0] r;
    src = '0;
    r   = '0;
    for (int k = 0; k < 10; k++) begin
      if (d == 4'(k)) src = SEGS[k];
    end
    for (int s = 0; s < 7; s++) begin
      if (src[s]) r[PERM[s]] = 1'b1;
    end
    return r;
  endfunction

  // Pin that carries the decimal point
  function automatic logic [7:0] dp_pins();
    logic [7:0] r;
    r = '0;
    r[PERM[DP_PIN]] = 1'b1;
    return r;
  endfunction

  // Global gain: min(level,10) * 255 / 10
  function automatic logic [7:0] level_gain(input logic [3:0] lvl);
    logic [7:0] g;
    case (lvl)
      4'd0:    g = 8'd0;
      4'd1:    g = 8'd25;
      4'd2:    g = 8'd51;
      4'd3:    g = 8'd76;
      4'd4:    g = 8'd102;
      4'd5:    g = 8'd127;
      4'd6:    g = 8'd153;
      4'd7:    g = 8'd178;
      4'd8:    g = 8'd204;
      4'd9:    g = 8'd229;
      default: g = 8'd255;
    endcase
    return g;
  endfunction

  // Truncating divide by 255, exact for values up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // Thousands digit of a 14-bit value taken modulo 10000, remainder below 1000
  function automatic split_t split_thousands(input logic [13:0] v);
    logic [4:0]  idx;
    logic [13:0] base;
    split_t      r;
    idx  = '0;
    base = '0;
    for (int k = 1; k <= 16; k++) begin
      if (v >= 14'(k * 1000)) begin
        idx  = 5'(k);
        base = 14'(k * 1000);
      end
    end
    r.digit = (idx >= 5'd10) ? 4'(idx - 5'd10) : 4'(idx);
    r.rest  = 10'(v - base);
    return r;
  endfunction

  // Hundreds digit of a value below 1024 taken modulo 1000, remainder below 100
  function automatic split_t split_hundreds(input logic [9:0] v);
    logic [3:0] idx;
    logic [9:0] base;
    split_t     r;
    idx  = '0;
    base = '0;
    for (int k = 1; k <= 10; k++) begin
      if (v >= 10'(k * 100)) begin
        idx  = 4'(k);
        base = 10'(k * 100);
      end
    end
    r.digit = (idx == 4'd10) ? 4'd0 : idx;
    r.rest  = v - base;
    return r;
  endfunction

  // Tens digit of a value below 100, remainder is the units digit
  function automatic split_t split_tens(input logic [6:0] v);
    logic [3:0] idx;
    logic [6:0] base;
    split_t     r;
    idx  = '0;
    base = '0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 7'(k * 10)) begin
        idx  = 4'(k);
        base = 7'(k * 10);
      end
    end
    r.digit = idx;
    r.rest  = 10'(v - base);
    return r;
  endfunction

endpackage

### hdl/seven_segment_pwm_frame_builder.sv
// Top level of the seven-segment PWM frame builder: digit split, segment mapping, frame output.

// Each accepted request (two 4-digit values, two 3-digit values, four decimal-point
// flags) yields STEP_COUNT frames of 14 segment bytes, one frame per clock cycle while
// m_axis_tready is high, steps 0 to STEP_COUNT-1, with tlast on the final one. The
// frame counter sets the sustained rate: one request per STEP_COUNT (32) frames. Three
// register stages split the values into decimal digits; a request passes stages 1 to 3,
// then the frame and output registers, before its first frame appears. The next request
// is taken in while the current run is still being sent and follows it without a gap.
// Brightness levels come from a three-stage pipeline off the configuration registers.
module seven_segment_pwm_frame_builder (
  input  logic                                 clk,
  input  logic                                 rst,
  // {second_three_digit_point, second_three_digit_value, first_three_digit_point,
  //  first_three_digit_value, second_four_digit_point, second_four_digit_value,
  //  first_four_digit_point, first_four_digit_value} from bit 51 down to bit 0
  input  logic [ssd_pwm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // frame_low [63:0], frame_high [111:64], step_index [116:112], zero pad above
  output logic [ssd_pwm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                                 m_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ssd_pwm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssd_pwm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ssd_pwm_pkg::*;

  // Configuration registers
  logic [3:0]  brightness_level;
  logic [63:0] digit_brightness_low;
  logic [47:0] digit_brightness_high;

  // Level pipeline
  logic [DIGIT_COUNT-1:0][15:0]      bright_prod;
  logic [DIGIT_COUNT-1:0][7:0]       bright_scaled;
  logic [DIGIT_COUNT-1:0][LVL_W-1:0] level;
  logic [FRAME_W-1:0]                digit_bright;

  // Stage 1: raw request
  logic              v1;
  logic [1:0][13:0]  s1_val4;
  logic [1:0][9:0]   s1_val3;
  logic [3:0]        s1_point;

  // Stage 2: leading digit split off
  logic              v2;
  logic [1:0][3:0]   s2_th4;
  logic [1:0][9:0]   s2_rem4;
  logic [1:0][3:0]   s2_h3;
  logic [1:0][6:0]   s2_rem3;
  logic [3:0]        s2_point;

  // Stage 3: second digit split off
  logic              v3;
  logic [1:0][3:0]   s3_th4;
  logic [1:0][3:0]   s3_h4;
  logic [1:0][6:0]   s3_rem4;
  logic [1:0][3:0]   s3_h3;
  logic [1:0][3:0]   s3_t3;
  logic [1:0][3:0]   s3_u3;
  logic [3:0]        s3_point;

  // Frame stage
  logic                              busy;
  logic [STEP_W-1:0]                 step;
  logic [DIGIT_COUNT-1:0][7:0]       frame_bytes;
  logic [DIGIT_COUNT-1:0][3:0]       load_digits;
  logic [DIGIT_COUNT-1:0][7:0]       load_bytes;
  logic [DIGIT_COUNT-1:0][7:0]       step_bytes;

  // Output register
  logic                   out_valid;
  logic                   out_last;
  logic [STEP_OUT_W-1:0]  out_step;
  logic [FRAME_W-1:0]     out_frame;

  // Handshake chain
  logic out_free, emit, last, frame_free, load3, s3_free, adv2, s2_free, adv1, s1_free;
  logic in_acc;

  split_t [1:0] sp_th4, sp_h3, sp_h4, sp_t3, sp_t4;

  assign out_free   = !out_valid || m_axis_tready;
  assign emit       = busy && out_free;
  assign last       = (step == STEP_W'(STEP_COUNT - 1));
  assign frame_free = !busy || (emit && last);
  assign load3      = v3 && frame_free;
  assign s3_free    = !v3 || frame_free;
  assign adv2       = v2 && s3_free;
  assign s2_free    = !v2 || s3_free;
  assign adv1       = v1 && s2_free;
  assign s1_free    = !v1 || s2_free;

  assign s_axis_tready = !rst && s1_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_level      <= 4'd10;
      digit_brightness_low  <= '1;
      digit_brightness_high <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BRIGHTNESS: brightness_level      <= cfg_data[3:0];
        CFG_DIGIT_LOW:  digit_brightness_low  <= cfg_data;
        CFG_DIGIT_HIGH: digit_brightness_high <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // Derive per-digit PWM levels: gain multiply, divide by 255, then scale by STEP_COUNT and divide by 255
  assign digit_bright = {digit_brightness_high, digit_brightness_low};

  always_ff @(posedge clk) begin
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      bright_prod[d]   <= 16'(digit_bright[8*d +: 8]) * 16'(level_gain(brightness_level));
      bright_scaled[d] <= div255(bright_prod[d]);
      level[d]         <= LVL_W'(div255(16'(bright_scaled[d]) * 16'(STEP_COUNT)));
    end
  end

  // Stage valids and frame control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      busy <= 1'b0;
      step <= '0;
    end else begin
      v1   <= in_acc || (v1 && !adv1);
      v2   <= adv1 || (v2 && !adv2);
      v3   <= adv2 || (v3 && !load3);
      busy <= load3 || (busy && !(emit && last));
      if (emit) begin
        step <= last ? '0 : step + STEP_W'(1);
      end
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_val4[0]  <= s_axis_tdata[13:0];
      s1_point[0] <= s_axis_tdata[14];
      s1_val4[1]  <= s_axis_tdata[28:15];
      s1_point[1] <= s_axis_tdata[29];
      s1_val3[0]  <= s_axis_tdata[39:30];
      s1_point[2] <= s_axis_tdata[40];
      s1_val3[1]  <= s_axis_tdata[50:41];
      s1_point[3] <= s_axis_tdata[51];
    end
  end

  // Split off the leading digits
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sp_th4[i] = split_thousands(s1_val4[i]);
      sp_h3[i]  = split_hundreds(s1_val3[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < 2; i++) begin
        s2_th4[i]  <= sp_th4[i].digit;
        s2_rem4[i] <= sp_th4[i].rest;
        s2_h3[i]   <= sp_h3[i].digit;
        s2_rem3[i] <= sp_h3[i].rest[6:0];
      end
      s2_point <= s1_point;
    end
  end

  // Split off the second digits
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sp_h4[i] = split_hundreds(s2_rem4[i]);
      sp_t3[i] = split_tens(s2_rem3[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      for (int i = 0; i < 2; i++) begin
        s3_th4[i]  <= s2_th4[i];
        s3_h4[i]   <= sp_h4[i].digit;
        s3_rem4[i] <= sp_h4[i].rest[6:0];
        s3_h3[i]   <= s2_h3[i];
        s3_t3[i]   <= sp_t3[i].digit;
        s3_u3[i]   <= sp_t3[i].rest[3:0];
      end
      s3_point <= s2_point;
    end
  end

  // Finish the 4-digit split and map every digit to pins
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sp_t4[i] = split_tens(s3_rem4[i]);
      load_digits[4*i + 0] = s3_th4[i];
      load_digits[4*i + 1] = s3_h4[i];
      load_digits[4*i + 2] = sp_t4[i].digit;
      load_digits[4*i + 3] = sp_t4[i].rest[3:0];
      load_digits[8 + 3*i + 0] = s3_h3[i];
      load_digits[8 + 3*i + 1] = s3_t3[i];
      load_digits[8 + 3*i + 2] = s3_u3[i];
    end
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      load_bytes[d] = seg_pins(load_digits[d]);
    end
    // Decimal point sits on the second digit of each display
    if (s3_point[0]) load_bytes[1]  = load_bytes[1]  | dp_pins();
    if (s3_point[1]) load_bytes[5]  = load_bytes[5]  | dp_pins();
    if (s3_point[2]) load_bytes[9]  = load_bytes[9]  | dp_pins();
    if (s3_point[3]) load_bytes[12] = load_bytes[12] | dp_pins();
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      frame_bytes <= load_bytes;
    end
  end

  // Gate each byte by its PWM level for the current step
  always_comb begin
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      step_bytes[d] = (LVL_W'(step) < level[d]) ? frame_bytes[d] : 8'd0;
    end
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_frame <= step_bytes;
      out_step  <= STEP_OUT_W'(step);
      out_last  <= last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {(OUT_TDATA_W - OUT_W)'(0), out_step, out_frame};

  // Final frame carries the last step index
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (out_step == STEP_OUT_W'(STEP_COUNT - 1)))
    else $error("tlast on a frame that is not the final step");

  // Frames of one run follow each other with consecutive steps
  a_step_follow: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && out_step == $past(out_step) + STEP_OUT_W'(1)))
    else $error("frame run broken or step skipped");

  // Idle frame stage keeps its counter at zero
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (step == '0))
    else $error("step counter not at zero while idle");

  // No frame appears from an empty frame stage
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (!busy && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("frame emitted with no run in progress");

endmodule

### bench/testbench.sv
// Self-checking testbench for the seven-segment PWM frame builder.
`timescale 1ns / 1ps

module testbench;
  import ssd_pwm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // index with no register behind it
  localparam int STALL_LIMIT = 3000;
  localparam logic [6:0] SEG_TABLE [10] = '{
    7'h3F, 7'h05, 7'h6E, 7'h4F, 7'h55, 7'h5B, 7'h7B, 7'h07, 7'h7F, 7'h5F
  };
  localparam int PIN_OF_SEG [8] = '{2, 0, 1, 3, 5, 4, 6, 7};

  typedef struct {
    logic [13:0] first_four;
    logic        first_four_dp;
    logic [13:0] second_four;
    logic        second_four_dp;
    logic [9:0]  first_three;
    logic        first_three_dp;
    logic [9:0]  second_three;
    logic        second_three_dp;
  } display_request_t;

  typedef struct {
    logic [63:0] frame_low;
    logic [47:0] frame_high;
    logic [4:0]  step_index;
    logic        last_step;
  } frame_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic [IN_TDATA_W-1:0]   s_axis_tdata;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tlast;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  // Shadow copy of the configuration registers
  logic [3:0]  bright_level;
  logic [63:0] digit_bright_low;
  logic [47:0] digit_bright_high;

  frame_t expected_frames [$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     sink_stall = 0;
  bit     quiet = 1'b0;

  seven_segment_pwm_frame_builder uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Segment bytes of one display, byte i in bits 8i+7:8i, most significant digit first
  function automatic logic [31:0] encode_display(input int value, input int ndig,
                                                 input logic dp);
    logic [31:0] r;
    logic [7:0]  b;
    int          v;
    int          div;
    int          dig;
    r = '0;
    v = value % ((ndig == 4) ? 10000 : 1000);
    for (int i = 0; i < ndig; i++) begin
      div = 1;
      for (int k = i + 1; k < ndig; k++) div *= 10;
      dig = (v / div) % 10;
      b = '0;
      for (int s = 0; s < 7; s++) begin
        if (SEG_TABLE[dig][s]) b[PIN_OF_SEG[s]] = 1'b1;
      end
      if (i == 1 && dp) b[PIN_OF_SEG[7]] = 1'b1;
      r[8*i +: 8] = b;
    end
    return r;
  endfunction

  // Work out the whole PWM run of one request and queue it
  function automatic void predict_frames(input display_request_t req);
    logic [7:0]   seg_bytes [DIGIT_COUNT];
    logic [31:0]  w;
    int           on_steps [DIGIT_COUNT];
    int           lvl;
    int           gain;
    int           db;
    frame_t       f;
    w = encode_display(req.first_four, 4, req.first_four_dp);
    for (int i = 0; i < 4; i++) seg_bytes[i] = w[8*i +: 8];
    w = encode_display(req.second_four, 4, req.second_four_dp);
    for (int i = 0; i < 4; i++) seg_bytes[4+i] = w[8*i +: 8];
    w = encode_display(req.first_three, 3, req.first_three_dp);
    for (int i = 0; i < 3; i++) seg_bytes[8+i] = w[8*i +: 8];
    w = encode_display(req.second_three, 3, req.second_three_dp);
    for (int i = 0; i < 3; i++) seg_bytes[11+i] = w[8*i +: 8];

    lvl  = (bright_level > 4'd10) ? 10 : int'(bright_level);
    gain = lvl * 255 / 10;
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      db = (d < 8) ? int'(digit_bright_low[8*d +: 8]) : int'(digit_bright_high[8*(d-8) +: 8]);
      on_steps[d] = (db * gain / 255) * STEP_COUNT / 255;
    end

    for (int step = 0; step < STEP_COUNT; step++) begin
      f.frame_low  = '0;
      f.frame_high = '0;
      for (int d = 0; d < DIGIT_COUNT; d++) begin
        if (step < on_steps[d]) begin
          if (d < 8) f.frame_low[8*d +: 8] = seg_bytes[d];
          else       f.frame_high[8*(d-8) +: 8] = seg_bytes[d];
        end
      end
      f.step_index = 5'(step);
      f.last_step  = (step == STEP_COUNT - 1);
      expected_frames.push_back(f);
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch in %s at %0t: got %h, expected %h", field, $realtime, got, want);
  endtask

  // Compare each accepted frame with the oldest expectation
  always @(posedge clk) begin
    frame_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected frame", m_axis_tdata[63:0], '0);
      end else begin
        want = expected_frames.pop_front();
        if (m_axis_tdata[63:0] !== want.frame_low)
          report_mismatch("frame_low", m_axis_tdata[63:0], want.frame_low);
        if (m_axis_tdata[111:64] !== want.frame_high)
          report_mismatch("frame_high", 64'(m_axis_tdata[111:64]), 64'(want.frame_high));
        if (m_axis_tdata[116:112] !== want.step_index)
          report_mismatch("step_index", 64'(m_axis_tdata[116:112]), 64'(want.step_index));
        if (m_axis_tlast !== want.last_step)
          report_mismatch("last_step", 64'(m_axis_tlast), 64'(want.last_step));
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      m_axis_tready = 1'b0;
      sink_stall--;
    end else begin
      m_axis_tready = 1'b1;
      if (!quiet && $urandom_range(0, 99) < 10)
        sink_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic send_request(input display_request_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tdata  = {4'b0, req.second_three_dp, req.second_three, req.first_three_dp,
                     req.first_three, req.second_four_dp, req.second_four,
                     req.first_four_dp, req.first_four};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_frames(req);
  endtask

  // Hold the sender until every expected frame has come out
  task automatic wait_for_drain();
    @(negedge clk) s_axis_tvalid = 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BRIGHTNESS: bright_level      = data[3:0];
      CFG_DIGIT_LOW:  digit_bright_low  = data;
      CFG_DIGIT_HIGH: digit_bright_high = data[47:0];
      default: ;
    endcase
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  // Drain, let the last run finish, write all registers, let the levels settle
  task automatic apply_settings(input logic [63:0] lvl_word, input logic [63:0] low,
                                input logic [63:0] high);
    wait_for_drain();
    repeat (8) @(posedge clk);
    write_register(CFG_BRIGHTNESS, lvl_word);
    write_register(CFG_DIGIT_LOW, low);
    write_register(CFG_DIGIT_HIGH, high);
    repeat (6) @(posedge clk);
  endtask

  function automatic display_request_t make_request(input int a, input int b, input int c,
                                                    input int d, input logic [3:0] dp);
    display_request_t r;
    r.first_four      = 14'(a);
    r.second_four     = 14'(b);
    r.first_three     = 10'(c);
    r.second_three    = 10'(d);
    r.first_four_dp   = dp[0];
    r.second_four_dp  = dp[1];
    r.first_three_dp  = dp[2];
    r.second_three_dp = dp[3];
    return r;
  endfunction

  function automatic int rand_four();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(9990, 10010);
      1:       return $urandom_range(16370, 16383);
      default: return $urandom_range(0, 16383);
    endcase
  endfunction

  function automatic int rand_three();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(990, 1010);
      1:       return $urandom_range(1015, 1023);
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  // Reset brightness: every digit fully on; value extremes, wrap-around and all digits
  task automatic test_value_extremes();
    send_request(make_request(0, 0, 0, 0, 4'b0000));
    send_request(make_request(16383, 16383, 1023, 1023, 4'b1111));
    send_request(make_request(9999, 10000, 999, 1000, 4'b0101));
    send_request(make_request(1234, 5678, 901, 234, 4'b1010));
    send_request(make_request(5678, 9012, 567, 890, 4'b0011));
    send_request(make_request(10001, 8888, 1001, 888, 4'b1100));
    send_request(make_request(12345, 7, 99, 5, 4'b1001));
  endtask

  // Per-digit brightness spread, global level off, mid, full and saturated
  task automatic test_brightness_levels();
    logic [63:0] spread_low;
    logic [63:0] spread_high;
    spread_low  = 64'hFF_FE_80_7F_10_08_01_00;
    spread_high = 64'h0000_00_01_7F_80_FE_FF;
    apply_settings(64'd10, spread_low, spread_high);
    send_request(make_request(8888, 8888, 888, 888, 4'b1111));
    send_request(make_request(1357, 2468, 135, 246, 4'b0110));
    apply_settings(64'd0, spread_low, spread_high);
    send_request(make_request(8888, 8888, 888, 888, 4'b1111));
    apply_settings(64'hFFFF_FFFF_FFFF_FFF5, spread_low, spread_high);
    send_request(make_request(8888, 8888, 888, 888, 4'b1111));
    apply_settings(64'd15, spread_low, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(make_request(8888, 8888, 888, 888, 4'b1111));
    apply_settings(64'd11, 64'h0, 64'h0);
    send_request(make_request(8888, 8888, 888, 888, 4'b1111));
    // a write to the spare index must change nothing
    apply_settings(64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF);
    write_register(CFG_SPARE, 64'h0);
    repeat (6) @(posedge clk);
    send_request(make_request(8888, 8888, 888, 888, 4'b1111));
  endtask

  // Random requests under several random register settings
  task automatic test_random_requests();
    logic [63:0] lvl_word;
    for (int phase = 0; phase < 5; phase++) begin
      lvl_word = {$urandom, $urandom};
      case (phase)
        0:       lvl_word[3:0] = 4'(10);
        1:       lvl_word[3:0] = 4'($urandom_range(11, 15));
        default: lvl_word[3:0] = 4'($urandom_range(1, 15));
      endcase
      apply_settings(lvl_word, {$urandom, $urandom}, {$urandom, $urandom});
      if ($urandom_range(0, 99) < 10) write_register(CFG_SPARE, {$urandom, $urandom});
      quiet = (phase == 2);
      for (int n = 0; n < 40; n++) begin
        if (n == 20 || $urandom_range(0, 99) < 3) wait_for_drain();
        send_request(make_request(rand_four(), rand_four(), rand_three(), rand_three(),
                                  4'($urandom_range(0, 15))));
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst               = 1'b1;
    s_axis_tvalid     = 1'b0;
    s_axis_tdata      = '0;
    cfg_valid         = 1'b0;
    cfg_index         = CFG_BRIGHTNESS;
    cfg_data          = '0;
    bright_level      = 4'd10;
    digit_bright_low  = '1;
    digit_bright_high = '1;
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    test_value_extremes();
    test_brightness_levels();
    test_random_requests();

    // Wait out the last run, then allow for stray frames
    wait_for_drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
